[hw/rtl/plbu_pkg.sv]
`timescale 1ns / 1ps
// Package for the price level book update block.
// Holds table sizes, entry layout, result status codes and the sequencing struct.
package plbu_pkg;

  localparam int LEVELS  = 4096;
  localparam int IDX_W   = $clog2(LEVELS);
  localparam int CNT_W   = $clog2(LEVELS + 1);
  localparam int PRICE_W = 48;
  localparam int QTY_W   = 48;
  localparam int ID_W    = 64;
  localparam int ENTRY_W = PRICE_W + QTY_W;
  localparam int OUT_CNT_W = 13;
  localparam int STATUS_W  = 3;

  localparam logic [STATUS_W-1:0] ST_APPLIED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STALE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RESET   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;

  typedef struct packed {
    logic bad;
    logic skip;
  } sync_dec_t;

endpackage

[hw/rtl/plbu_ram.sv]
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Generic; used for the bid and ask level tables.
module plbu_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/plbu_sync.sv]
`timescale 1ns / 1ps
// Message sequencing state: synced flag, last seen update id and skip flag.
// Depends on plbu_pkg.
module plbu_sync (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     eval,
  input  logic                     book_clear,
  input  logic                     message_start,
  input  logic [plbu_pkg::ID_W-1:0] first_id,
  input  logic [plbu_pkg::ID_W-1:0] final_id,
  output plbu_pkg::sync_dec_t      dec
);
  import plbu_pkg::*;

  logic            synced;
  logic [ID_W-1:0] last_seen_id;
  logic            message_skipping;
  logic            synced_next;
  logic [ID_W-1:0] last_seen_id_next;
  logic            skip_next;

  always_comb begin
    synced_next       = synced;
    last_seen_id_next = last_seen_id;
    skip_next         = message_skipping;
    dec.bad           = 1'b0;
    if (message_start) begin
      if (final_id < first_id) begin
        skip_next = 1'b1;
        dec.bad   = 1'b1;
      end else if (!synced) begin
        if (final_id <= last_seen_id) begin
          skip_next = 1'b1;
        end else begin
          synced_next       = 1'b1;
          skip_next         = 1'b0;
          last_seen_id_next = final_id;
        end
      end else if (first_id <= last_seen_id && final_id <= last_seen_id) begin
        skip_next = 1'b1;
      end else begin
        skip_next         = 1'b0;
        last_seen_id_next = final_id;
      end
    end
    dec.skip = skip_next;
  end

  always_ff @(posedge clk) begin
    if (rst || book_clear) begin
      synced           <= 1'b0;
      last_seen_id     <= '0;
      message_skipping <= 1'b0;
    end else if (eval) begin
      synced           <= synced_next;
      last_seen_id     <= last_seen_id_next;
      message_skipping <= skip_next;
    end
  end

endmodule

[hw/rtl/price_level_book_update_top.sv]
`timescale 1ns / 1ps
// Top level of the price level book update block: sequencer over two level RAMs.
// Depends on plbu_pkg, plbu_ram and plbu_sync.
//
//  channel  | signals                                   | handshake
//  request  | command side price quantity first_id      | start, taken when busy is low
//           | final_id message_start message_end        |
//  result   | status best_* bid_levels ask_levels       | done, one cycle, no stall
//           | asks_uncrossed                            |
//
// One request is processed at a time; busy is high from the cycle after start until done.
// The search reads and compares each level visited, each shifted level is read and then
// written (S_MV_RD, S_MV_WR), and the uncross checks each ask and shifts each ask moved;
// the pace is set by the single read and write port of each RAM.
// Reset clears counts and sequencing state; table contents need no clearing.
module price_level_book_update_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic                           side,
  input  logic [plbu_pkg::PRICE_W-1:0]   price,
  input  logic [plbu_pkg::QTY_W-1:0]     quantity,
  input  logic [plbu_pkg::ID_W-1:0]      first_id,
  input  logic [plbu_pkg::ID_W-1:0]      final_id,
  input  logic                           message_start,
  input  logic                           message_end,
  output logic                           done,
  output logic [plbu_pkg::STATUS_W-1:0]  status,
  output logic [plbu_pkg::PRICE_W-1:0]   best_bid_price,
  output logic [plbu_pkg::QTY_W-1:0]     best_bid_quantity,
  output logic [plbu_pkg::PRICE_W-1:0]   best_ask_price,
  output logic [plbu_pkg::QTY_W-1:0]     best_ask_quantity,
  output logic [plbu_pkg::OUT_CNT_W-1:0] bid_levels,
  output logic [plbu_pkg::OUT_CNT_W-1:0] ask_levels,
  output logic [plbu_pkg::OUT_CNT_W-1:0] asks_uncrossed
);
  import plbu_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_SRCH_RD  = 15'b000000000000010,
    S_SRCH_CMP = 15'b000000000000100,
    S_DECIDE   = 15'b000000000001000,
    S_MV_RD    = 15'b000000000010000,
    S_MV_WR    = 15'b000000000100000,
    S_PUT      = 15'b000000001000000,
    S_AFTER    = 15'b000000010000000,
    S_UNX_RD   = 15'b000000100000000,
    S_UNX_BEST = 15'b000001000000000,
    S_UNX_SRD  = 15'b000010000000000,
    S_UNX_SCMP = 15'b000100000000000,
    S_UNX_DONE = 15'b001000000000000,
    S_TOP_RD   = 15'b010000000000000,
    S_TOP_OUT  = 15'b100000000000000
  } state_t;

  localparam logic [CNT_W-1:0] LEVELS_C = CNT_W'(LEVELS);
  localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);

  state_t               state;
  state_t               ret;
  logic                 side_q;
  logic                 wside;
  logic                 end_q;
  logic [PRICE_W-1:0]   price_q;
  logic [QTY_W-1:0]     qty_q;
  logic [STATUS_W-1:0]  status_q;
  logic [CNT_W-1:0]     bid_fill;
  logic [CNT_W-1:0]     ask_fill;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     src;
  logic [CNT_W-1:0]     dst;
  logic [CNT_W-1:0]     moves;
  logic                 up;
  logic                 hit;
  logic [CNT_W-1:0]     k;
  logic [CNT_W-1:0]     removed;
  logic [PRICE_W-1:0]   best;

  logic                 accept;
  sync_dec_t            dec;
  logic [CNT_W-1:0]     n;
  logic [PRICE_W-1:0]   rprice;
  logic                 ahead;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 wr_en;
  logic [ENTRY_W-1:0]   bid_rd;
  logic [ENTRY_W-1:0]   ask_rd;
  logic [ENTRY_W-1:0]   side_rd;
  state_t               after_st;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign n        = side_q ? ask_fill : bid_fill;
  assign side_rd  = wside ? ask_rd : bid_rd;
  assign rprice   = side_rd[ENTRY_W-1:QTY_W];
  assign ahead    = side_q ? (price_q <= rprice) : (price_q >= rprice);
  assign after_st = end_q ? S_UNX_RD : S_TOP_RD;

  plbu_sync u_sync (
    .clk          (clk),
    .rst          (rst),
    .eval         (accept && !command),
    .book_clear   (accept && command),
    .message_start(message_start),
    .first_id     (first_id),
    .final_id     (final_id),
    .dec          (dec)
  );

  always_comb begin
    case (state)
      S_SRCH_RD: rd_addr = pos[IDX_W-1:0];
      S_MV_RD:   rd_addr = src[IDX_W-1:0];
      S_UNX_SRD: rd_addr = k[IDX_W-1:0];
      default:   rd_addr = '0;
    endcase
    wr_en   = (state == S_MV_WR) || (state == S_PUT);
    wr_addr = (state == S_MV_WR) ? dst[IDX_W-1:0] : pos[IDX_W-1:0];
    wr_data = (state == S_MV_WR) ? side_rd : {price_q, qty_q};
  end

  plbu_ram #(.DEPTH(LEVELS), .WIDTH(ENTRY_W)) u_bid_ram (
    .clk    (clk),
    .wr_en  (wr_en && !wside),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(bid_rd)
  );

  plbu_ram #(.DEPTH(LEVELS), .WIDTH(ENTRY_W)) u_ask_ram (
    .clk    (clk),
    .wr_en  (wr_en && wside),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(ask_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bid_fill <= '0;
      ask_fill <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            side_q  <= side;
            wside   <= side;
            end_q   <= message_end;
            price_q <= price;
            qty_q   <= quantity;
            removed <= '0;
            pos     <= '0;
            if (command) begin
              bid_fill <= '0;
              ask_fill <= '0;
              status_q <= ST_RESET;
              state    <= S_TOP_RD;
            end else if (dec.bad) begin
              status_q <= ST_INVALID;
              state    <= S_TOP_RD;
            end else if (dec.skip) begin
              status_q <= ST_STALE;
              state    <= S_TOP_RD;
            end else if (price == '0) begin
              status_q <= ST_INVALID;
              state    <= S_AFTER;
            end else begin
              status_q <= ST_APPLIED;
              state    <= S_SRCH_RD;
            end
          end
        end
        S_SRCH_RD: begin
          if (pos == n) begin
            hit   <= 1'b0;
            state <= S_DECIDE;
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (ahead) begin
            hit   <= (rprice == price_q);
            state <= S_DECIDE;
          end else begin
            pos   <= pos + ONE_C;
            state <= S_SRCH_RD;
          end
        end
        S_DECIDE: begin
          if (hit) begin
            if (qty_q == '0) begin
              if (side_q) begin
                ask_fill <= ask_fill - ONE_C;
              end else begin
                bid_fill <= bid_fill - ONE_C;
              end
              moves <= n - pos - ONE_C;
              src   <= pos + ONE_C;
              dst   <= pos;
              up    <= 1'b1;
              ret   <= S_AFTER;
              state <= (n - pos == ONE_C) ? S_AFTER : S_MV_RD;
            end else begin
              state <= S_PUT;
            end
          end else if (qty_q == '0) begin
            state <= S_AFTER;
          end else if (n < LEVELS_C) begin
            if (side_q) begin
              ask_fill <= ask_fill + ONE_C;
            end else begin
              bid_fill <= bid_fill + ONE_C;
            end
            moves <= n - pos;
            src   <= n - ONE_C;
            dst   <= n;
            up    <= 1'b0;
            ret   <= S_PUT;
            state <= (n == pos) ? S_PUT : S_MV_RD;
          end else begin
            status_q <= ST_DROPPED;
            if (pos == LEVELS_C) begin
              state <= S_AFTER;
            end else begin
              moves <= LEVELS_C - ONE_C - pos;
              src   <= LEVELS_C - CNT_W'(2);
              dst   <= LEVELS_C - ONE_C;
              up    <= 1'b0;
              ret   <= S_PUT;
              state <= (pos == LEVELS_C - ONE_C) ? S_PUT : S_MV_RD;
            end
          end
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          moves <= moves - ONE_C;
          src   <= up ? src + ONE_C : src - ONE_C;
          dst   <= up ? dst + ONE_C : dst - ONE_C;
          state <= (moves == ONE_C) ? ret : S_MV_RD;
        end
        S_PUT: begin
          state <= S_AFTER;
        end
        S_AFTER: begin
          state <= after_st;
        end
        S_UNX_RD: begin
          wside <= 1'b0;
          state <= (bid_fill == '0) ? S_TOP_RD : S_UNX_BEST;
        end
        S_UNX_BEST: begin
          best  <= rprice;
          k     <= '0;
          wside <= 1'b1;
          state <= S_UNX_SRD;
        end
        S_UNX_SRD: begin
          state <= (k == ask_fill) ? S_UNX_DONE : S_UNX_SCMP;
        end
        S_UNX_SCMP: begin
          if (rprice <= best) begin
            k     <= k + ONE_C;
            state <= S_UNX_SRD;
          end else begin
            state <= S_UNX_DONE;
          end
        end
        S_UNX_DONE: begin
          removed  <= k;
          ask_fill <= ask_fill - k;
          moves    <= ask_fill - k;
          src      <= k;
          dst      <= '0;
          up       <= 1'b1;
          ret      <= S_TOP_RD;
          state    <= (k == '0 || k == ask_fill) ? S_TOP_RD : S_MV_RD;
        end
        S_TOP_RD: begin
          state <= S_TOP_OUT;
        end
        S_TOP_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done              = (state == S_TOP_OUT);
  assign status            = status_q;
  assign best_bid_price    = (bid_fill != '0) ? bid_rd[ENTRY_W-1:QTY_W] : '0;
  assign best_bid_quantity = (bid_fill != '0) ? bid_rd[QTY_W-1:0] : '0;
  assign best_ask_price    = (ask_fill != '0) ? ask_rd[ENTRY_W-1:QTY_W] : '0;
  assign best_ask_quantity = (ask_fill != '0) ? ask_rd[QTY_W-1:0] : '0;
  assign bid_levels        = OUT_CNT_W'(bid_fill);
  assign ask_levels        = OUT_CNT_W'(ask_fill);
  assign asks_uncrossed    = OUT_CNT_W'(removed);

endmodule

[hw/rtl/plbu_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the price level book update block, bound to the top level.
// Depends on plbu_pkg.
module plbu_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [plbu_pkg::STATUS_W-1:0]  status,
  input logic [plbu_pkg::OUT_CNT_W-1:0] bid_levels,
  input logic [plbu_pkg::OUT_CNT_W-1:0] ask_levels,
  input logic [plbu_pkg::OUT_CNT_W-1:0] asks_uncrossed
);
  import plbu_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request taken but block not busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !busy) else $error("result not ending the request");

  a_reset_levels: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_RESET |-> bid_levels == '0 && ask_levels == '0)
    else $error("book reset left levels");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    done |-> bid_levels <= OUT_CNT_W'(LEVELS) && ask_levels <= OUT_CNT_W'(LEVELS))
    else $error("level count out of range");

  a_uncross_only_applied: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_STALE || status == ST_RESET) |-> asks_uncrossed == '0)
    else $error("uncross on skipped request");

endmodule

bind price_level_book_update_top plbu_checker u_plbu_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .bid_levels    (bid_levels),
  .ask_levels    (ask_levels),
  .asks_uncrossed(asks_uncrossed)
);
